FILE: hdl/isodt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isodt_pkg
// Shared types, constants and tables of the ISO 8601 timestamp parser.
// ----------------------------------------------------------------------------
package isodt_pkg;

  // Year digits allowed (4..6) and fraction digits kept (1..9).
  localparam int MAX_YEAR_DIGITS = 6;
  localparam int MIN_YEAR_DIGITS = 4;
  localparam int FRAC_DIGITS     = 9;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;

  // Resolution codes.
  localparam logic [2:0] RES_INVALID = 3'd0;
  localparam logic [2:0] RES_YEAR    = 3'd1;
  localparam logic [2:0] RES_MONTH   = 3'd2;
  localparam logic [2:0] RES_DAY     = 3'd3;
  localparam logic [2:0] RES_HOUR    = 3'd4;
  localparam logic [2:0] RES_MINUTE  = 3'd5;
  localparam logic [2:0] RES_SECOND  = 3'd6;
  localparam logic [2:0] RES_SUBSEC  = 3'd7;

  // Field limits and defaults.
  localparam logic [6:0] MONTH_MAX = 7'd12;
  localparam logic [6:0] DAY_MAX   = 7'd31;
  localparam logic [6:0] HOUR_MAX  = 7'd24;
  localparam logic [6:0] MIN_MAX   = 7'd60;
  localparam logic [6:0] SEC_MAX   = 7'd61;
  localparam logic signed [20:0] DEFAULT_YEAR = 21'sd1970;

  typedef enum logic [2:0] {
    CC_DIGIT,
    CC_DASH,
    CC_PLUS,
    CC_COLON,
    CC_DOT,
    CC_T,
    CC_Z,
    CC_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        last;
  } token_t;

  typedef enum logic [10:0] {
    PH_START = 11'b000_0000_0001,
    PH_YEAR  = 11'b000_0000_0010,
    PH_MONTH = 11'b000_0000_0100,
    PH_DAY   = 11'b000_0000_1000,
    PH_HOUR  = 11'b000_0001_0000,
    PH_MIN   = 11'b000_0010_0000,
    PH_SEC   = 11'b000_0100_0000,
    PH_FRAC  = 11'b000_1000_0000,
    PH_ZULU  = 11'b001_0000_0000,
    PH_ZH    = 11'b010_0000_0000,
    PH_ZM    = 11'b100_0000_0000
  } phase_t;

  // Weight of the fraction digit at a given position, in nanoseconds.
  function automatic logic [29:0] frac_weight(input logic [3:0] idx);
    logic [29:0] w;
    case (idx)
      4'd0:    w = 30'd100000000;
      4'd1:    w = 30'd10000000;
      4'd2:    w = 30'd1000000;
      4'd3:    w = 30'd100000;
      4'd4:    w = 30'd10000;
      4'd5:    w = 30'd1000;
      4'd6:    w = 30'd100;
      4'd7:    w = 30'd10;
      4'd8:    w = 30'd1;
      default: w = 30'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/isodt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isodt_front
// Accepts text bytes and classifies each into a token for the parser.
// ----------------------------------------------------------------------------
module isodt_front (
  input  logic                 in_valid,
  input  logic [7:0]           char_code,
  input  logic                 last_char,
  output logic                 push_valid,
  output isodt_pkg::token_t    push_token
);

  isodt_pkg::char_class_t cls;

  always_comb begin
    unique case (char_code) inside
      [isodt_pkg::CH_ZERO:isodt_pkg::CH_NINE]: cls = isodt_pkg::CC_DIGIT;
      isodt_pkg::CH_DASH:                      cls = isodt_pkg::CC_DASH;
      isodt_pkg::CH_PLUS:                      cls = isodt_pkg::CC_PLUS;
      isodt_pkg::CH_COLON:                     cls = isodt_pkg::CC_COLON;
      isodt_pkg::CH_DOT:                       cls = isodt_pkg::CC_DOT;
      isodt_pkg::CH_T:                         cls = isodt_pkg::CC_T;
      isodt_pkg::CH_Z:                         cls = isodt_pkg::CC_Z;
      default:                                 cls = isodt_pkg::CC_OTHER;
    endcase
  end

  assign push_valid       = in_valid;
  assign push_token.cls   = cls;
  // low nibble of '0'..'9' is the digit value
  assign push_token.digit = char_code[3:0];
  assign push_token.last  = last_char;

endmodule

FILE: hdl/isodt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isodt_queue
// Short token queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module isodt_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  isodt_pkg::token_t    push_token,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output isodt_pkg::token_t    pop_token
);

  localparam int PW = isodt_pkg::QUEUE_PTR_W;
  localparam int CW = isodt_pkg::QUEUE_CNT_W;

  isodt_pkg::token_t entry [isodt_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(isodt_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_token  = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(isodt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(isodt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_token;
    end
  end

endmodule

FILE: hdl/isodt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isodt_back
// Parser state machine: consumes tokens, builds the fields, and registers
// one result at the end of each text.
// ----------------------------------------------------------------------------
module isodt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  isodt_pkg::token_t    pop_token,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           resolution,
  output logic signed [20:0]   year,
  output logic [3:0]           month,
  output logic [4:0]           day,
  output logic [4:0]           hour,
  output logic [5:0]           minute,
  output logic [5:0]           whole_seconds,
  output logic [29:0]          fraction_ns,
  output logic signed [5:0]    zone_hours,
  output logic signed [6:0]    zone_minutes
);

  isodt_pkg::phase_t phase, phase_next;
  logic [3:0]  digit_count, digit_count_next;
  logic [20:0] year_accum, year_accum_next;
  logic        year_negative, year_negative_next;
  logic [3:0]  month_reg, month_reg_next;
  logic [4:0]  day_reg, day_reg_next;
  logic [4:0]  hour_reg, hour_reg_next;
  logic [5:0]  minute_reg, minute_reg_next;
  logic [5:0]  seconds_reg, seconds_reg_next;
  logic [29:0] frac_reg, frac_reg_next;
  logic [3:0]  fraction_count, fraction_count_next;
  logic [4:0]  zone_hours_reg, zone_hours_reg_next;
  logic [5:0]  zone_minutes_reg, zone_minutes_reg_next;
  logic        zone_negative, zone_negative_next;
  logic        error_seen, error_seen_next;
  logic [2:0]  resolution_reg, resolution_reg_next;

  logic        go;
  logic        is_dig;
  logic [3:0]  dval;
  logic [6:0]  cur2;
  logic [6:0]  lo2;
  logic [6:0]  hi2;
  logic [6:0]  acc2;
  logic        f2_take;
  logic        f2_err;
  logic [2:0]  end_res;
  logic [2:0]  time_res;

  assign go        = pop_valid && pop_ready;
  // only the final token of a text needs room in the output register
  assign pop_ready = !pop_token.last || !out_valid || out_ready;
  assign is_dig    = (pop_token.cls == isodt_pkg::CC_DIGIT);
  assign dval      = pop_token.digit;

  // shared two-digit field datapath
  always_comb begin
    cur2     = '0;
    lo2      = '0;
    hi2      = '0;
    time_res = isodt_pkg::RES_HOUR;
    unique case (phase)
      isodt_pkg::PH_MONTH: begin
        cur2 = 7'(month_reg);
        lo2  = 7'd1;
        hi2  = isodt_pkg::MONTH_MAX;
      end
      isodt_pkg::PH_DAY: begin
        cur2 = 7'(day_reg);
        lo2  = 7'd1;
        hi2  = isodt_pkg::DAY_MAX;
      end
      isodt_pkg::PH_HOUR: begin
        cur2     = 7'(hour_reg);
        hi2      = isodt_pkg::HOUR_MAX;
        time_res = isodt_pkg::RES_HOUR;
      end
      isodt_pkg::PH_MIN: begin
        cur2     = 7'(minute_reg);
        hi2      = isodt_pkg::MIN_MAX;
        time_res = isodt_pkg::RES_MINUTE;
      end
      isodt_pkg::PH_SEC: begin
        cur2     = 7'(seconds_reg);
        hi2      = isodt_pkg::SEC_MAX;
        time_res = isodt_pkg::RES_SECOND;
      end
      isodt_pkg::PH_ZH: begin
        cur2 = 7'(zone_hours_reg);
        hi2  = isodt_pkg::HOUR_MAX;
      end
      isodt_pkg::PH_ZM: begin
        cur2 = 7'(zone_minutes_reg);
        hi2  = isodt_pkg::MIN_MAX;
      end
      default: begin
        cur2 = '0;
      end
    endcase
    acc2    = 7'(cur2 * 7'd10) + 7'(dval);
    f2_take = (digit_count < 4'd2);
    f2_err  = f2_take && (!is_dig ||
              ((digit_count == 4'd1) && ((acc2 < lo2) || (acc2 > hi2))));
  end

  always_comb begin
    phase_next            = phase;
    digit_count_next      = digit_count;
    year_accum_next       = year_accum;
    year_negative_next    = year_negative;
    month_reg_next        = month_reg;
    day_reg_next          = day_reg;
    hour_reg_next         = hour_reg;
    minute_reg_next       = minute_reg;
    seconds_reg_next      = seconds_reg;
    frac_reg_next         = frac_reg;
    fraction_count_next   = fraction_count;
    zone_hours_reg_next   = zone_hours_reg;
    zone_minutes_reg_next = zone_minutes_reg;
    zone_negative_next    = zone_negative;
    error_seen_next       = error_seen;
    resolution_reg_next   = resolution_reg;

    if (!error_seen) begin
      unique case (phase)
        isodt_pkg::PH_START: begin
          if (pop_token.cls == isodt_pkg::CC_DASH) begin
            year_negative_next = 1'b1;
            phase_next         = isodt_pkg::PH_YEAR;
          end else if (is_dig) begin
            year_accum_next  = 21'(dval);
            digit_count_next = 4'd1;
            phase_next       = isodt_pkg::PH_YEAR;
          end else begin
            error_seen_next = 1'b1;
          end
        end
        isodt_pkg::PH_YEAR: begin
          if (is_dig) begin
            if (digit_count >= 4'(isodt_pkg::MAX_YEAR_DIGITS)) begin
              error_seen_next = 1'b1;
            end else begin
              year_accum_next  = 21'(year_accum * 21'd10) + 21'(dval);
              digit_count_next = digit_count + 4'd1;
            end
          end else if ((pop_token.cls == isodt_pkg::CC_DASH) &&
                       (digit_count >= 4'(isodt_pkg::MIN_YEAR_DIGITS))) begin
            phase_next       = isodt_pkg::PH_MONTH;
            digit_count_next = '0;
          end else begin
            error_seen_next = 1'b1;
          end
        end
        isodt_pkg::PH_MONTH, isodt_pkg::PH_DAY, isodt_pkg::PH_ZH: begin
          if (f2_take) begin
            if (f2_err) begin
              error_seen_next = 1'b1;
            end else begin
              digit_count_next = digit_count + 4'd1;
              if (phase == isodt_pkg::PH_MONTH) begin
                month_reg_next = acc2[3:0];
              end else if (phase == isodt_pkg::PH_DAY) begin
                day_reg_next = acc2[4:0];
              end else begin
                zone_hours_reg_next = acc2[4:0];
              end
            end
          end else begin
            digit_count_next = '0;
            if ((phase == isodt_pkg::PH_MONTH) &&
                (pop_token.cls == isodt_pkg::CC_DASH)) begin
              phase_next = isodt_pkg::PH_DAY;
            end else if ((phase == isodt_pkg::PH_DAY) &&
                         (pop_token.cls == isodt_pkg::CC_T)) begin
              phase_next = isodt_pkg::PH_HOUR;
            end else if ((phase == isodt_pkg::PH_ZH) &&
                         (pop_token.cls == isodt_pkg::CC_COLON)) begin
              phase_next = isodt_pkg::PH_ZM;
            end else begin
              error_seen_next = 1'b1;
            end
          end
        end
        isodt_pkg::PH_HOUR, isodt_pkg::PH_MIN, isodt_pkg::PH_SEC: begin
          if (f2_take) begin
            if (f2_err) begin
              error_seen_next = 1'b1;
            end else begin
              digit_count_next = digit_count + 4'd1;
              if (phase == isodt_pkg::PH_HOUR) begin
                hour_reg_next = acc2[4:0];
              end else if (phase == isodt_pkg::PH_MIN) begin
                minute_reg_next = acc2[5:0];
              end else begin
                seconds_reg_next = acc2[5:0];
              end
            end
          end else begin
            digit_count_next = '0;
            if ((phase == isodt_pkg::PH_HOUR) &&
                (pop_token.cls == isodt_pkg::CC_COLON)) begin
              phase_next = isodt_pkg::PH_MIN;
            end else if ((phase == isodt_pkg::PH_MIN) &&
                         (pop_token.cls == isodt_pkg::CC_COLON)) begin
              phase_next = isodt_pkg::PH_SEC;
            end else if ((phase == isodt_pkg::PH_SEC) &&
                         (pop_token.cls == isodt_pkg::CC_DOT)) begin
              phase_next = isodt_pkg::PH_FRAC;
            end else begin
              // zone entry after a time field
              resolution_reg_next = time_res;
              if (pop_token.cls == isodt_pkg::CC_Z) begin
                phase_next = isodt_pkg::PH_ZULU;
              end else if ((pop_token.cls == isodt_pkg::CC_PLUS) ||
                           (pop_token.cls == isodt_pkg::CC_DASH)) begin
                zone_negative_next = (pop_token.cls == isodt_pkg::CC_DASH);
                phase_next         = isodt_pkg::PH_ZH;
              end else begin
                error_seen_next = 1'b1;
              end
            end
          end
        end
        isodt_pkg::PH_FRAC: begin
          if (is_dig) begin
            // digits past the kept precision are dropped
            if (fraction_count < 4'(isodt_pkg::FRAC_DIGITS)) begin
              frac_reg_next = frac_reg +
                              30'(dval * isodt_pkg::frac_weight(fraction_count));
              fraction_count_next = fraction_count + 4'd1;
            end
          end else if (fraction_count == '0) begin
            error_seen_next = 1'b1;
          end else begin
            resolution_reg_next = isodt_pkg::RES_SUBSEC;
            digit_count_next    = '0;
            if (pop_token.cls == isodt_pkg::CC_Z) begin
              phase_next = isodt_pkg::PH_ZULU;
            end else if ((pop_token.cls == isodt_pkg::CC_PLUS) ||
                         (pop_token.cls == isodt_pkg::CC_DASH)) begin
              zone_negative_next = (pop_token.cls == isodt_pkg::CC_DASH);
              phase_next         = isodt_pkg::PH_ZH;
            end else begin
              error_seen_next = 1'b1;
            end
          end
        end
        isodt_pkg::PH_ZM: begin
          if (f2_take && !f2_err) begin
            zone_minutes_reg_next = acc2[5:0];
            digit_count_next      = digit_count + 4'd1;
          end else begin
            error_seen_next = 1'b1;
          end
        end
        default: begin
          // anything after 'Z' is trailing garbage
          error_seen_next = 1'b1;
        end
      endcase
    end
  end

  // resolution if the text ends after this token
  always_comb begin
    end_res = isodt_pkg::RES_INVALID;
    if (!error_seen_next) begin
      unique case (phase_next)
        isodt_pkg::PH_YEAR: begin
          if (digit_count_next >= 4'(isodt_pkg::MIN_YEAR_DIGITS)) begin
            end_res = isodt_pkg::RES_YEAR;
          end
        end
        isodt_pkg::PH_MONTH: begin
          if (digit_count_next == 4'd2) begin
            end_res = isodt_pkg::RES_MONTH;
          end
        end
        isodt_pkg::PH_DAY: begin
          if (digit_count_next == 4'd2) begin
            end_res = isodt_pkg::RES_DAY;
          end
        end
        isodt_pkg::PH_ZULU: begin
          end_res = resolution_reg_next;
        end
        isodt_pkg::PH_ZH, isodt_pkg::PH_ZM: begin
          if (digit_count_next == 4'd2) begin
            end_res = resolution_reg_next;
          end
        end
        default: begin
          end_res = isodt_pkg::RES_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (go && pop_token.last)) begin
      phase            <= isodt_pkg::PH_START;
      digit_count      <= '0;
      year_accum       <= '0;
      year_negative    <= 1'b0;
      month_reg        <= '0;
      day_reg          <= '0;
      hour_reg         <= '0;
      minute_reg       <= '0;
      seconds_reg      <= '0;
      frac_reg         <= '0;
      fraction_count   <= '0;
      zone_hours_reg   <= '0;
      zone_minutes_reg <= '0;
      zone_negative    <= 1'b0;
      error_seen       <= 1'b0;
      resolution_reg   <= '0;
    end else if (go) begin
      phase            <= phase_next;
      digit_count      <= digit_count_next;
      year_accum       <= year_accum_next;
      year_negative    <= year_negative_next;
      month_reg        <= month_reg_next;
      day_reg          <= day_reg_next;
      hour_reg         <= hour_reg_next;
      minute_reg       <= minute_reg_next;
      seconds_reg      <= seconds_reg_next;
      frac_reg         <= frac_reg_next;
      fraction_count   <= fraction_count_next;
      zone_hours_reg   <= zone_hours_reg_next;
      zone_minutes_reg <= zone_minutes_reg_next;
      zone_negative    <= zone_negative_next;
      error_seen       <= error_seen_next;
      resolution_reg   <= resolution_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && pop_token.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && pop_token.last) begin
      resolution <= end_res;
      if (end_res == isodt_pkg::RES_INVALID) begin
        year          <= isodt_pkg::DEFAULT_YEAR;
        month         <= 4'd1;
        day           <= 5'd1;
        hour          <= '0;
        minute        <= '0;
        whole_seconds <= '0;
        fraction_ns   <= '0;
        zone_hours    <= '0;
        zone_minutes  <= '0;
      end else begin
        year          <= year_negative_next ? -$signed(year_accum_next)
                                            : $signed(year_accum_next);
        month         <= (end_res >= isodt_pkg::RES_MONTH)  ? month_reg_next : 4'd1;
        day           <= (end_res >= isodt_pkg::RES_DAY)    ? day_reg_next : 5'd1;
        hour          <= (end_res >= isodt_pkg::RES_HOUR)   ? hour_reg_next : 5'd0;
        minute        <= (end_res >= isodt_pkg::RES_MINUTE) ? minute_reg_next : 6'd0;
        whole_seconds <= (end_res >= isodt_pkg::RES_SECOND) ? seconds_reg_next : 6'd0;
        fraction_ns   <= (end_res >= isodt_pkg::RES_SUBSEC) ? frac_reg_next : 30'd0;
        zone_hours    <= zone_negative_next ? -$signed({1'b0, zone_hours_reg_next})
                                            : $signed({1'b0, zone_hours_reg_next});
        zone_minutes  <= zone_negative_next ? -$signed({1'b0, zone_minutes_reg_next})
                                            : $signed({1'b0, zone_minutes_reg_next});
      end
    end
  end

endmodule

FILE: hdl/iso8601_datetime_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8601_datetime_parser_core
// Streaming ISO 8601 timestamp parser: one character in, one result per text.
// ----------------------------------------------------------------------------
// Feed the text one byte per request on the input channel and raise last_char
// on its final byte; exactly one result request follows for each text, in
// order. Accepted form: optional '-', a year of 4 to MAX_YEAR_DIGITS digits,
// then optionally -MM, -DD, THH, :MM, :SS and .fraction, each only after the
// one before it. Once an hour is given a zone is required: 'Z', or '+'/'-'
// with two hour digits and optional :MM; both zone fields carry the zone's
// sign. Invalid text returns resolution 0 with year 1970, month and day 1 and
// everything else 0. The fraction is reported in nanoseconds; digits beyond
// FRAC_DIGITS are dropped. Throughput is one character per cycle sustained:
// the classifier, the two-entry token queue and the parser each move one
// character a cycle, and the parser's per-character step (one two-digit
// field update plus one fraction digit weight) sets that figure. With an empty
// queue, the final character is held in a queue entry and then in the result
// register. The parser stalls only when a final character meets a result that
// has not yet been taken; input keeps flowing into the queue until it fills.
// ----------------------------------------------------------------------------
module iso8601_datetime_parser_core (
  input  logic                 clk,
  input  logic                 rst,
  // text bytes
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           char_code,
  input  logic                 last_char,
  // parsed results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           resolution,
  output logic signed [20:0]   year,
  output logic [3:0]           month,
  output logic [4:0]           day,
  output logic [4:0]           hour,
  output logic [5:0]           minute,
  output logic [5:0]           whole_seconds,
  output logic [29:0]          fraction_ns,
  output logic signed [5:0]    zone_hours,
  output logic signed [6:0]    zone_minutes
);

  logic              push_valid;
  isodt_pkg::token_t push_token;
  logic              pop_valid;
  logic              pop_ready;
  isodt_pkg::token_t pop_token;

  // front: character classification
  isodt_front u_front (
    .in_valid   (in_valid),
    .char_code  (char_code),
    .last_char  (last_char),
    .push_valid (push_valid),
    .push_token (push_token)
  );

  // decoupling queue; its free space is the input ready
  isodt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (in_ready),
    .push_token (push_token),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_token  (pop_token)
  );

  // back: parse state machine and result register
  isodt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_token     (pop_token),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .resolution    (resolution),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .whole_seconds (whole_seconds),
    .fraction_ns   (fraction_ns),
    .zone_hours    (zone_hours),
    .zone_minutes  (zone_minutes)
  );

endmodule

FILE: hdl/isodt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isodt_checker
// Port-level checks of the timestamp parser, bound to the top level.
// ----------------------------------------------------------------------------
module isodt_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [7:0]           char_code,
  input logic                 last_char,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [2:0]           resolution,
  input logic signed [20:0]   year,
  input logic [3:0]           month,
  input logic [4:0]           day,
  input logic [4:0]           hour,
  input logic [5:0]           minute,
  input logic [5:0]           whole_seconds,
  input logic [29:0]          fraction_ns,
  input logic signed [5:0]    zone_hours,
  input logic signed [6:0]    zone_minutes
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(resolution) && $stable(year)
      && $stable(fraction_ns) && $stable(zone_minutes))
    else $error("result changed while stalled");

  // invalid text carries the default fields
  a_invalid_defaults: assert property (@(posedge clk) disable iff (rst)
    out_valid && (resolution == isodt_pkg::RES_INVALID) |->
      (year == isodt_pkg::DEFAULT_YEAR) && (month == 4'd1) && (day == 5'd1) &&
      (hour == 5'd0) && (minute == 6'd0) && (whole_seconds == 6'd0) &&
      (fraction_ns == 30'd0) && (zone_hours == 6'sd0) && (zone_minutes == 7'sd0))
    else $error("invalid result with non-default fields");

  // valid results respect the field limits
  a_limits: assert property (@(posedge clk) disable iff (rst)
    out_valid && (resolution != isodt_pkg::RES_INVALID) |->
      (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) && (day <= 5'd31) &&
      (hour <= 5'd24) && (minute <= 6'd60) && (whole_seconds <= 6'd61) &&
      (fraction_ns <= 30'd999999999))
    else $error("field out of range");

  // no zone without an hour
  a_zone_needs_hour: assert property (@(posedge clk) disable iff (rst)
    out_valid && (resolution < isodt_pkg::RES_HOUR) |->
      (zone_hours == 6'sd0) && (zone_minutes == 7'sd0) && (hour == 5'd0))
    else $error("zone or hour present below hour resolution");

  // zone hours and minutes never disagree in sign
  a_zone_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(((zone_hours < 6'sd0) && (zone_minutes > 7'sd0)) ||
                    ((zone_hours > 6'sd0) && (zone_minutes < 7'sd0))))
    else $error("zone fields with opposite signs");

endmodule

bind iso8601_datetime_parser_core isodt_checker u_isodt_checker (.*);

FILE: verif/iso8601_datetime_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8601_datetime_parser_core_tb
// Self-checking bench for the streaming ISO 8601 timestamp parser.
// ----------------------------------------------------------------------------
// Timestamp texts go in one byte per request, with last_char on the final
// byte. A behavioral parser in this file follows every accepted byte and
// queues the timestamp that each text must produce; each result request is
// compared field by field against the oldest queued timestamp.
// A directed table of texts comes first (year extremes, each resolution, the
// field limits, zone forms and the usual malformed texts), then random texts:
// mostly well-formed with random values, some corrupted, some plain noise.
// Both channels stall at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module iso8601_datetime_parser_core_tb;
  import isodt_pkg::*;

  localparam int DIR_ROWS     = 25;
  localparam int RANDOM_CHARS = 1700;   // parsed bytes in the random part
  localparam int NS_DIGITS    = 9;      // fraction is reported in 1e-9 s
  localparam int DRAIN_CYCLES = 5000;
  localparam int MAX_REPORTS  = 10;

  // One parsed timestamp, laid out like the result ports.
  typedef struct packed {
    logic [2:0]         resolution;
    logic signed [20:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         seconds;
    logic [29:0]        frac_ns;
    logic signed [5:0]  zone_h;
    logic signed [6:0]  zone_m;
  } stamp_t;

  // Directed row: the text, and a hand-written timestamp where it is obvious.
  typedef struct {
    string  text;
    bit     typed;
    stamp_t want;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // DUT hookup. All inputs start at known values.
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [7:0]          char_code = 8'h00;
  logic                last_char = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          resolution;
  logic signed [20:0]  year;
  logic [3:0]          month;
  logic [4:0]          day;
  logic [4:0]          hour;
  logic [5:0]          minute;
  logic [5:0]          whole_seconds;
  logic [29:0]         fraction_ns;
  logic signed [5:0]   zone_hours;
  logic signed [6:0]   zone_minutes;

  iso8601_datetime_parser_core uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .last_char     (last_char),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .resolution    (resolution),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .whole_seconds (whole_seconds),
    .fraction_ns   (fraction_ns),
    .zone_hours    (zone_hours),
    .zone_minutes  (zone_minutes)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  stamp_t     pending_stamps[$];   // timestamps still owed by the DUT
  logic [7:0] text_buf[$];         // text being sent
  bit         steady = 1'b0;       // no stalls on either side while set
  bit         use_typed = 1'b0;    // current text carries a hand-written result
  stamp_t     typed_want;
  int         fails = 0;
  int         live_chars = 0;      // bytes the parser actually looked at
  int         texts_sent = 0;
  int         results_seen = 0;
  bit [7:0]   res_hit = '0;        // resolution codes predicted so far

  // --------------------------------------------------------------------------
  // Behavioral parser. Widths follow the DUT except the 32-bit year accumulator
  // and the two-digit fields: 7 bits, so an out-of-range pair like 99 is caught.
  // --------------------------------------------------------------------------
  phase_t      ph;
  logic [3:0]  ndig;
  logic [31:0] yr_acc;
  logic        yr_neg;
  logic [6:0]  mo_r, dy_r, hr_r, mi_r, se_r, zh_r, zm_r;
  logic [29:0] fr_acc;
  logic [3:0]  fr_cnt;
  logic        zn_neg;
  logic        bad;                // sticky: rest of the text is ignored
  logic [2:0]  zone_res;           // resolution latched when the zone opens
  logic [6:0]  pair_val;           // updated two-digit field from take_pair

  function automatic stamp_t stamp(int r, int y, int mo, int d, int h, int mi,
                                   int s, int f, int zh, int zm);
    stamp_t t;
    t.resolution = r[2:0];
    t.year       = y[20:0];
    t.month      = mo[3:0];
    t.day        = d[4:0];
    t.hour       = h[4:0];
    t.minute     = mi[5:0];
    t.seconds    = s[5:0];
    t.frac_ns    = f[29:0];
    t.zone_h     = zh[5:0];
    t.zone_m     = zm[6:0];
    return t;
  endfunction

  function automatic stamp_t invalid_stamp();
    return stamp(RES_INVALID, DEFAULT_YEAR, 1, 1, 0, 0, 0, 0, 0, 0);
  endfunction

  function automatic void clear_parser();
    ph       = PH_START;
    ndig     = '0;
    yr_acc   = '0;
    yr_neg   = 1'b0;
    mo_r     = '0;
    dy_r     = '0;
    hr_r     = '0;
    mi_r     = '0;
    se_r     = '0;
    zh_r     = '0;
    zm_r     = '0;
    fr_acc   = '0;
    fr_cnt   = '0;
    zn_neg   = 1'b0;
    bad      = 1'b0;
    zone_res = RES_INVALID;
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void advance(phase_t nxt);
    ph   = nxt;
    ndig = '0;
  endfunction

  function automatic logic [2:0] phase_res(phase_t p);
    case (p)
      PH_YEAR:  return RES_YEAR;
      PH_MONTH: return RES_MONTH;
      PH_DAY:   return RES_DAY;
      PH_HOUR:  return RES_HOUR;
      PH_MIN:   return RES_MINUTE;
      PH_SEC:   return RES_SECOND;
      PH_FRAC:  return RES_SUBSEC;
      default:  return RES_INVALID;
    endcase
  endfunction

  // Two-digit field: -1 bad, 0 digit taken, 1 field already full (c is the
  // separator that follows). New field value is left in pair_val.
  function automatic int take_pair(logic [6:0] acc, logic [6:0] lo, logic [6:0] hi,
                                   logic [7:0] c);
    pair_val = acc;
    if (ndig >= 2) return 1;
    if (!is_num(c)) return -1;
    pair_val = acc * 7'd10 + (c - CH_ZERO);
    ndig++;
    if (ndig == 2 && (pair_val < lo || pair_val > hi)) return -1;
    return 0;
  endfunction

  // A time field or fraction ended on c; c must open a zone.
  function automatic bit open_zone(logic [7:0] c);
    zone_res = phase_res(ph);
    ndig     = '0;
    if (c == CH_Z) begin
      ph = PH_ZULU;
      return 1'b1;
    end
    if (c == CH_PLUS || c == CH_DASH) begin
      zn_neg = (c == CH_DASH);
      ph     = PH_ZH;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    int r;
    case (ph)
      PH_START: begin
        if (c == CH_DASH) begin
          yr_neg = 1'b1;
          ph     = PH_YEAR;
        end else if (is_num(c)) begin
          yr_acc = c - CH_ZERO;
          ndig   = 4'd1;
          ph     = PH_YEAR;
        end else begin
          bad = 1'b1;
        end
      end
      PH_YEAR: begin
        if (is_num(c)) begin
          if (ndig >= MAX_YEAR_DIGITS) begin
            bad = 1'b1;   // year too long
          end else begin
            yr_acc = yr_acc * 10 + (c - CH_ZERO);
            ndig++;
          end
        end else if (c == CH_DASH && ndig >= MIN_YEAR_DIGITS) begin
          advance(PH_MONTH);
        end else begin
          bad = 1'b1;
        end
      end
      PH_MONTH: begin
        r    = take_pair(mo_r, 7'd1, MONTH_MAX, c);
        mo_r = pair_val;
        if (r < 0 || (r == 1 && c != CH_DASH)) bad = 1'b1;
        else if (r == 1) advance(PH_DAY);
      end
      PH_DAY: begin
        r    = take_pair(dy_r, 7'd1, DAY_MAX, c);
        dy_r = pair_val;
        if (r < 0 || (r == 1 && c != CH_T)) bad = 1'b1;
        else if (r == 1) advance(PH_HOUR);
      end
      PH_HOUR, PH_MIN, PH_SEC: begin
        if (ph == PH_HOUR) begin
          r    = take_pair(hr_r, 7'd0, HOUR_MAX, c);
          hr_r = pair_val;
        end else if (ph == PH_MIN) begin
          r    = take_pair(mi_r, 7'd0, MIN_MAX, c);
          mi_r = pair_val;
        end else begin
          r    = take_pair(se_r, 7'd0, SEC_MAX, c);
          se_r = pair_val;
        end
        if (r < 0) begin
          bad = 1'b1;
        end else if (r == 1) begin
          if (ph == PH_HOUR && c == CH_COLON) advance(PH_MIN);
          else if (ph == PH_MIN && c == CH_COLON) advance(PH_SEC);
          else if (ph == PH_SEC && c == CH_DOT) advance(PH_FRAC);
          else if (!open_zone(c)) bad = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_num(c)) begin
          // digits past the kept precision are dropped
          if (fr_cnt < FRAC_DIGITS) begin
            fr_acc = fr_acc * 10 + (c - CH_ZERO);
            fr_cnt++;
          end
        end else if (fr_cnt == 0 || !open_zone(c)) begin
          bad = 1'b1;
        end
      end
      PH_ZH: begin
        r    = take_pair(zh_r, 7'd0, HOUR_MAX, c);
        zh_r = pair_val;
        if (r < 0 || (r == 1 && c != CH_COLON)) bad = 1'b1;
        else if (r == 1) advance(PH_ZM);
      end
      PH_ZM: begin
        r    = take_pair(zm_r, 7'd0, MIN_MAX, c);
        zm_r = pair_val;
        if (r != 0) bad = 1'b1;   // anything after the zone minutes
      end
      default: bad = 1'b1;        // byte after 'Z'
    endcase
  endfunction

  // Resolution if the text ends here, invalid if it cannot end here.
  function automatic logic [2:0] end_res();
    if (bad) return RES_INVALID;
    case (ph)
      PH_YEAR:          return (ndig >= MIN_YEAR_DIGITS) ? RES_YEAR : RES_INVALID;
      PH_MONTH, PH_DAY: return (ndig == 2) ? phase_res(ph) : RES_INVALID;
      PH_ZULU:          return zone_res;
      PH_ZH, PH_ZM:     return (ndig == 2) ? zone_res : RES_INVALID;
      default:          return RES_INVALID;   // includes a missing zone
    endcase
  endfunction

  // Timestamp for the text just finished; parser goes back to its reset state.
  function automatic stamp_t close_text();
    stamp_t      t;
    logic [2:0]  r;
    logic [63:0] f;
    int          i;
    r = end_res();
    if (r == RES_INVALID) begin
      t = invalid_stamp();
    end else begin
      t.resolution = r;
      t.year       = yr_neg ? -yr_acc[20:0] : yr_acc[20:0];
      t.month      = (r >= RES_MONTH)  ? mo_r[3:0] : 4'd1;
      t.day        = (r >= RES_DAY)    ? dy_r[4:0] : 5'd1;
      t.hour       = (r >= RES_HOUR)   ? hr_r[4:0] : 5'd0;
      t.minute     = (r >= RES_MINUTE) ? mi_r[5:0] : 6'd0;
      t.seconds    = (r >= RES_SECOND) ? se_r[5:0] : 6'd0;
      f = '0;
      if (r >= RES_SUBSEC) begin
        f = fr_acc;
        for (i = fr_cnt; i < NS_DIGITS; i++) f = f * 10;
      end
      t.frac_ns = f[29:0];
      // both zone fields carry the zone sign; "-00:00" comes out as zero
      t.zone_h  = zn_neg ? -zh_r[5:0] : zh_r[5:0];
      t.zone_m  = zn_neg ? -zm_r : zm_r;
    end
    clear_parser();
    return t;
  endfunction

  // Called on every accepted input request.
  function automatic void note_accepted(logic [7:0] c, logic fin);
    stamp_t t;
    if (!bad) begin
      live_chars++;
      parse_byte(c);
    end
    if (fin) begin
      t = close_text();
      if (use_typed) t = typed_want;
      res_hit[t.resolution] = 1'b1;
      pending_stamps.push_back(t);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Random text construction
  // --------------------------------------------------------------------------
  function automatic void put_pair(int v);
    text_buf.push_back(CH_ZERO + v / 10);
    text_buf.push_back(CH_ZERO + v % 10);
  endfunction

  function automatic void put_digits(int n);
    repeat (n) text_buf.push_back(CH_ZERO + $urandom_range(0, 9));
  endfunction

  // Two-digit value: mostly legal, with the limits and the odd illegal one.
  function automatic int pick(int lo, int hi);
    case ($urandom_range(0, 9))
      0:       return lo;
      1:       return hi;
      2:       return $urandom_range(0, 99);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Byte for corruption: often a separator or digit, otherwise anything.
  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 15))
      0:       return CH_DASH;
      1:       return CH_PLUS;
      2:       return CH_COLON;
      3:       return CH_DOT;
      4:       return CH_T;
      5:       return CH_Z;
      6, 7:    return CH_ZERO + $urandom_range(0, 9);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic void build_random_text();
    int         kind, depth, n, k;
    logic [7:0] spare;
    text_buf = {};
    kind = $urandom_range(0, 99);
    if (kind >= 92) begin
      // plain noise
      n = $urandom_range(1, 8);
      repeat (n) text_buf.push_back(any_byte());
      return;
    end
    if ($urandom_range(0, 4) == 0) text_buf.push_back(CH_DASH);
    case ($urandom_range(0, 19))
      0:       n = $urandom_range(1, MIN_YEAR_DIGITS - 1);
      1:       n = MAX_YEAR_DIGITS + 1;
      default: n = $urandom_range(MIN_YEAR_DIGITS, MAX_YEAR_DIGITS);
    endcase
    put_digits(n);
    depth = $urandom_range(RES_YEAR, RES_SUBSEC);
    if (depth >= RES_MONTH) begin
      text_buf.push_back(CH_DASH);
      put_pair(pick(1, MONTH_MAX));
    end
    if (depth >= RES_DAY) begin
      text_buf.push_back(CH_DASH);
      put_pair(pick(1, DAY_MAX));
    end
    if (depth >= RES_HOUR) begin
      text_buf.push_back(CH_T);
      put_pair(pick(0, HOUR_MAX));
    end
    if (depth >= RES_MINUTE) begin
      text_buf.push_back(CH_COLON);
      put_pair(pick(0, MIN_MAX));
    end
    if (depth >= RES_SECOND) begin
      text_buf.push_back(CH_COLON);
      put_pair(pick(0, SEC_MAX));
    end
    if (depth >= RES_SUBSEC) begin
      text_buf.push_back(CH_DOT);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(FRAC_DIGITS + 1, FRAC_DIGITS + 3)
                                      : $urandom_range(1, FRAC_DIGITS);
      put_digits(n);
    end
    if (depth >= RES_HOUR) begin
      k = $urandom_range(0, 19);
      if (k >= 1 && k <= 6) begin
        text_buf.push_back(CH_Z);
      end else if (k > 6) begin
        text_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
        put_pair(pick(0, HOUR_MAX));
        if ($urandom_range(0, 1)) begin
          text_buf.push_back(CH_COLON);
          put_pair(pick(0, MIN_MAX));
        end
      end
      // k == 0: zone left out on purpose
    end
    if (kind >= 75) begin
      // corrupt a good text: overwrite, insert or cut short
      k = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(0, 2))
        0:       text_buf[k] = any_byte();
        1:       text_buf.insert(k, any_byte());
        default: while (text_buf.size() > k + 1) spare = text_buf.pop_back();
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side: drive at the falling edge, see the request taken at the
  // rising edge. One assignment to in_valid per falling edge.
  // --------------------------------------------------------------------------
  task automatic drive_byte(logic [7:0] c, logic fin);
    while (!steady && $urandom_range(0, 99) < 25) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    char_code <= c;
    last_char <= fin;
    do @(posedge clk); while (!in_ready);
    note_accepted(c, fin);
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_buf.size(); i++) drive_byte(text_buf[i], i == text_buf.size() - 1);
    texts_sent++;
  endtask

  // Sender holds off until every owed result has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random back-pressure, checking at the rising edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 25);
  end

  function automatic string show(stamp_t t);
    return $sformatf("res=%0d %0d-%0d-%0d %0d:%0d:%0d frac=%0d zone=%0d:%0d",
                     t.resolution, t.year, t.month, t.day, t.hour, t.minute,
                     t.seconds, t.frac_ns, t.zone_h, t.zone_m);
  endfunction

  function automatic string diff_fields(stamp_t w, stamp_t g);
    string s;
    s = "";
    if (w.resolution !== g.resolution) s = {s, " resolution"};
    if (w.year       !== g.year)       s = {s, " year"};
    if (w.month      !== g.month)      s = {s, " month"};
    if (w.day        !== g.day)        s = {s, " day"};
    if (w.hour       !== g.hour)       s = {s, " hour"};
    if (w.minute     !== g.minute)     s = {s, " minute"};
    if (w.seconds    !== g.seconds)    s = {s, " whole_seconds"};
    if (w.frac_ns    !== g.frac_ns)    s = {s, " fraction_ns"};
    if (w.zone_h     !== g.zone_h)     s = {s, " zone_hours"};
    if (w.zone_m     !== g.zone_m)     s = {s, " zone_minutes"};
    return s;
  endfunction

  function automatic void note_failure(string msg);
    fails++;
    if (fails <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  always @(posedge clk) begin : result_check
    stamp_t got;
    stamp_t want;
    string  diffs;
    if (!rst && out_valid && out_ready) begin
      got = {resolution, year, month, day, hour, minute, whole_seconds,
             fraction_ns, zone_hours, zone_minutes};
      results_seen++;
      if (pending_stamps.size() == 0) begin
        note_failure({"result with nothing owed: ", show(got)});
      end else begin
        want  = pending_stamps.pop_front();
        diffs = diff_fields(want, got);
        if (diffs != "")
          note_failure($sformatf("result %0d, wrong:%s\n  expected %s\n  actual   %s",
                                 results_seen, diffs, show(want), show(got)));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t dir_rows[DIR_ROWS];
    int       i, j, k, base, rand_texts;

    dir_rows = '{
      // year only, right after reset, and year extremes
      '{"1970",     1'b1, stamp(RES_YEAR, 1970, 1, 1, 0, 0, 0, 0, 0, 0)},
      '{"-999999",  1'b1, stamp(RES_YEAR, -999999, 1, 1, 0, 0, 0, 0, 0, 0)},
      '{"0000",     1'b1, stamp(RES_YEAR, 0, 1, 1, 0, 0, 0, 0, 0, 0)},
      '{"1234567",  1'b1, invalid_stamp()},    // year too long
      '{"123",      1'b1, invalid_stamp()},    // year too short
      '{"-",        1'b1, invalid_stamp()},
      '{"A",        1'b1, invalid_stamp()},
      // date fields and their limits
      '{"2024-12",    1'b1, stamp(RES_MONTH, 2024, 12, 1, 0, 0, 0, 0, 0, 0)},
      '{"2024-13",    1'b1, invalid_stamp()},
      '{"2024-01-31", 1'b1, stamp(RES_DAY, 2024, 1, 31, 0, 0, 0, 0, 0, 0)},
      '{"2024-02-00", 1'b1, invalid_stamp()},
      '{"2024-",      1'b1, invalid_stamp()},
      // time fields, each at its upper limit in one of the rows
      '{"2024-06-15T24Z", 1'b1, stamp(RES_HOUR, 2024, 6, 15, 24, 0, 0, 0, 0, 0)},
      '{"2024-06-15T23:60:61Z", 1'b1,
        stamp(RES_SECOND, 2024, 6, 15, 23, 60, 61, 0, 0, 0)},
      '{"2024-06-15T12:30:45.1Z", 1'b0, invalid_stamp()},
      // extra fraction digits are truncated; zone at its limits
      '{"2024-06-15T12:30:45.123456789123+24:60", 1'b1,
        stamp(RES_SUBSEC, 2024, 6, 15, 12, 30, 45, 123456789, 24, 60)},
      '{"2024-06-15T12:30-00:00", 1'b0, invalid_stamp()},   // negative zero zone
      '{"2024-06-15T12:30-05:30", 1'b0, invalid_stamp()},
      '{"2024-06-15T12+05",       1'b0, invalid_stamp()},
      // malformed: missing zone, trailing byte, empty fraction, bad zone,
      // single-digit field
      '{"2024-06-15T12",          1'b1, invalid_stamp()},
      '{"2024-06-15T12ZX",        1'b1, invalid_stamp()},
      '{"2024-06-15T12:30:45.Z",  1'b1, invalid_stamp()},
      '{"2024-06-15T12+25",       1'b1, invalid_stamp()},
      '{"2024-06-15T12+01:61",    1'b1, invalid_stamp()},
      '{"2024-06-15T1Z",          1'b1, invalid_stamp()}
    };

    clear_parser();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) begin
      text_buf = {};
      for (j = 0; j < dir_rows[i].text.len(); j++) text_buf.push_back(dir_rows[i].text[j]);
      use_typed  = dir_rows[i].typed;
      typed_want = dir_rows[i].want;
      send_text();
    end
    use_typed = 1'b0;
    hold_until_drained();

    // random texts; one stretch runs with no stalls, and the sender waits
    // for the result queue to empty once midway
    base       = live_chars;
    rand_texts = 0;
    while (live_chars - base < RANDOM_CHARS) begin
      steady = (rand_texts >= 30 && rand_texts < 50);
      if (rand_texts == 60) hold_until_drained();
      build_random_text();
      send_text();
      rand_texts++;
    end
    steady = 1'b0;

    // let the last results come out, then watch for strays
    @(negedge clk);
    in_valid <= 1'b0;
    for (k = 0; k < DRAIN_CYCLES && pending_stamps.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_stamps.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_stamps.size()));

    $display("Sent %0d texts (%0d bytes parsed), %0d results compared, %0d errors",
             texts_sent, live_chars, results_seen, fails);
    $display("Resolution codes exercised (bit n = code n): %b", res_hit);
    if (fails == 0) begin
      $display("iso8601_datetime_parser_core regression: pass");
    end else begin
      $display("iso8601_datetime_parser_core regression: fail");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("iso8601_datetime_parser_core regression: fail");
    $finish;
  end

endmodule

FILE: files.f
hdl/isodt_pkg.sv
hdl/isodt_front.sv
hdl/isodt_queue.sv
hdl/isodt_back.sv
hdl/iso8601_datetime_parser_core.sv
hdl/isodt_checker.sv
verif/iso8601_datetime_parser_core_tb.sv
